// ===== hw/rtl/trie_dictionary_with_visit_count_unit_assert.svh =====
// Assertion macros used by the trie dictionary RTL.
`ifndef TRIE_DICTIONARY_WITH_VISIT_COUNT_UNIT_ASSERT_SVH
`define TRIE_DICTIONARY_WITH_VISIT_COUNT_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TDVC_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define TDVC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/tdvc_pkg.sv =====
`default_nettype none

package tdvc_pkg;

  // Sizes of the trie storage.
  localparam int NODES       = 1024;
  localparam int CHILD_SLOTS = 32;
  localparam int COUNT_BITS  = 16;

  localparam int NODE_W   = $clog2(NODES);
  localparam int SLOT_W   = $clog2(CHILD_SLOTS);
  localparam int TBL_W    = NODE_W + SLOT_W;
  localparam int LETTER_W = 5;

  // Operation carried by an input beat.
  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_QUERY  = 1'b1
  } op_t;

  // Result codes.
  typedef enum logic [2:0] {
    ST_INSERTED = 3'd0,
    ST_FIRST    = 3'd1,
    ST_REPEAT   = 3'd2,
    ST_UNKNOWN  = 3'd3,
    ST_FULL     = 3'd4
  } status_t;

  // Sequencer states.
  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_WALK,
    S_FINISH
  } state_t;

endpackage

`default_nettype wire

// ===== hw/rtl/tdvc_ifs.sv =====
`default_nettype none

// Input channel: one character of a word per beat.
interface tdvc_in_if;
  logic                               valid;
  logic                               ready;
  tdvc_pkg::op_t                      operation;
  logic [tdvc_pkg::LETTER_W-1:0]      letter;
  logic                               last;

  modport source (output valid, output operation, output letter, output last,
                  input ready);
  modport sink   (input valid, input operation, input letter, input last,
                  output ready);
endinterface

// Result channel: one beat per completed word.
interface tdvc_out_if;
  logic                               valid;
  logic                               ready;
  tdvc_pkg::status_t                  status;
  logic [tdvc_pkg::COUNT_BITS-1:0]    visit_count;

  modport source (output valid, output status, output visit_count, input ready);
  modport sink   (input valid, input status, input visit_count, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/trie_dictionary_with_visit_count_unit.sv =====
// Trie dictionary with per-node visit counters. Words arrive one character per
// input beat (operation, letter, last flag); an insert allocates missing child
// nodes, a query follows existing ones, and the last character of each word
// yields one result beat with a status and, for a known word, its saturating
// visit count. After reset the block sweeps its child table clear, one entry
// a cycle, through all 32768 entries (NODES * CHILD_SLOTS) before it takes
// any input. A character that is not last, on a live walk, goes through a read
// of the child table and then the update of the walk that uses it. Once the
// walk of a word has failed, such a character is taken with nothing read. A
// last character on a live walk adds a third step, the read-modify-write of
// the node's end mark and counter; after a failed walk it goes straight to
// that final step, which then writes nothing back. It stays in its final step
// longer only while a previous result has not been taken.
`default_nettype none
`include "trie_dictionary_with_visit_count_unit_assert.svh"

module trie_dictionary_with_visit_count_unit (
  input  wire logic clk,
  input  wire logic rst_n,
  tdvc_in_if.sink   in_if,
  tdvc_out_if.source out_if
);
  import tdvc_pkg::*;

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  // Memories: child numbers per (node, slot), and {end mark, counter} per node.
  logic [NODE_W-1:0]     tbl_mem [NODES*CHILD_SLOTS];
  logic [COUNT_BITS:0]   node_mem [NODES];

  state_t                state_r, state_nxt;
  logic [TBL_W-1:0]      clr_r, clr_nxt;
  logic [NODE_W-1:0]     cursor_r, cursor_nxt;
  logic [NODE_W-1:0]     nodes_used_r, nodes_used_nxt;
  logic                  walk_failed_r, walk_failed_nxt;
  op_t                   op_r;
  logic                  last_r;
  logic [TBL_W-1:0]      slot_addr_r;

  logic                  out_valid_r, out_valid_nxt;
  status_t               status_r, status_nxt;
  logic [COUNT_BITS-1:0] count_r, count_nxt;

  logic                  tbl_we, tbl_re;
  logic [TBL_W-1:0]      tbl_waddr, tbl_raddr;
  logic [NODE_W-1:0]     tbl_wdata, tbl_rdata_r;
  logic                  node_we, node_re;
  logic [NODE_W-1:0]     node_waddr, node_raddr;
  logic [COUNT_BITS:0]   node_wdata, node_rdata_r;

  logic                  in_fire, letter_ok, fin_go;
  logic [NODE_W-1:0]     new_node;
  logic [COUNT_BITS-1:0] cnt_old, cnt_inc;
  logic                  mark_old;

  assign in_if.ready  = (state_r == S_IDLE);
  assign in_fire      = in_if.valid && in_if.ready;
  assign letter_ok    = (32'(in_if.letter) < CHILD_SLOTS);
  assign fin_go       = !out_valid_r || out_if.ready;
  assign new_node     = nodes_used_r + NODE_W'(1);
  assign mark_old     = node_rdata_r[COUNT_BITS];
  assign cnt_old      = node_rdata_r[COUNT_BITS-1:0];
  assign cnt_inc      = (cnt_old == COUNT_MAX) ? cnt_old : cnt_old + COUNT_BITS'(1);

  assign out_if.valid       = out_valid_r;
  assign out_if.status      = status_r;
  assign out_if.visit_count = count_r;

  // Next state, walk update and memory port control.
  always_comb begin
    state_nxt       = state_r;
    clr_nxt         = clr_r;
    cursor_nxt      = cursor_r;
    nodes_used_nxt  = nodes_used_r;
    walk_failed_nxt = walk_failed_r;
    out_valid_nxt   = out_valid_r && !out_if.ready;
    status_nxt      = status_r;
    count_nxt       = count_r;
    tbl_we          = 1'b0;
    tbl_waddr       = slot_addr_r;
    tbl_wdata       = new_node;
    tbl_re          = 1'b0;
    tbl_raddr       = {cursor_r, SLOT_W'(in_if.letter)};
    node_we         = 1'b0;
    node_waddr      = cursor_r;
    node_wdata      = node_rdata_r;
    node_re         = 1'b0;
    node_raddr      = cursor_r;

    case (state_r)
      S_CLEAR: begin
        tbl_we    = 1'b1;
        tbl_waddr = clr_r;
        tbl_wdata = '0;
        if (clr_r[TBL_W-1 -: SLOT_W] == '0) begin
          node_we    = 1'b1;
          node_waddr = clr_r[NODE_W-1:0];
          node_wdata = '0;
        end
        clr_nxt = clr_r + TBL_W'(1);
        if (clr_r == '1) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_fire) begin
          if (walk_failed_r || !letter_ok) begin
            walk_failed_nxt = 1'b1;
            state_nxt       = in_if.last ? S_FINISH : S_IDLE;
          end else begin
            tbl_re    = 1'b1;
            state_nxt = S_WALK;
          end
        end
      end
      S_WALK: begin
        if (tbl_rdata_r != '0) begin
          cursor_nxt = tbl_rdata_r;
        end else if (op_r == OP_INSERT && nodes_used_r < NODE_W'(NODES - 1)) begin
          nodes_used_nxt = new_node;
          tbl_we         = 1'b1;
          cursor_nxt     = new_node;
        end else begin
          walk_failed_nxt = 1'b1;
        end
        if (last_r) begin
          node_re    = 1'b1;
          node_raddr = cursor_nxt;
          state_nxt  = S_FINISH;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_FINISH: begin
        if (fin_go) begin
          out_valid_nxt = 1'b1;
          count_nxt     = '0;
          if (walk_failed_r) begin
            status_nxt = (op_r == OP_INSERT) ? ST_FULL : ST_UNKNOWN;
          end else if (op_r == OP_INSERT) begin
            node_we    = 1'b1;
            node_wdata = {1'b1, cnt_old};
            status_nxt = ST_INSERTED;
          end else begin
            node_we    = 1'b1;
            node_wdata = {mark_old, cnt_inc};
            if (mark_old) begin
              status_nxt = (cnt_old == '0) ? ST_FIRST : ST_REPEAT;
              count_nxt  = cnt_inc;
            end else begin
              status_nxt = ST_UNKNOWN;
            end
          end
          cursor_nxt      = '0;
          walk_failed_nxt = 1'b0;
          state_nxt       = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_CLEAR;
      clr_r         <= '0;
      cursor_r      <= '0;
      nodes_used_r  <= '0;
      walk_failed_r <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      clr_r         <= clr_nxt;
      cursor_r      <= cursor_nxt;
      nodes_used_r  <= nodes_used_nxt;
      walk_failed_r <= walk_failed_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  // Beat payload and result registers.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      op_r        <= in_if.operation;
      last_r      <= in_if.last;
      slot_addr_r <= {cursor_r, SLOT_W'(in_if.letter)};
    end
    status_r <= status_nxt;
    count_r  <= count_nxt;
  end

  // Child table port.
  always_ff @(posedge clk) begin
    if (tbl_we) begin
      tbl_mem[tbl_waddr] <= tbl_wdata;
    end
    if (tbl_re) begin
      tbl_rdata_r <= tbl_mem[tbl_raddr];
    end
  end

  // Node mark and counter port.
  always_ff @(posedge clk) begin
    if (node_we) begin
      node_mem[node_waddr] <= node_wdata;
    end
    if (node_re) begin
      node_rdata_r <= node_mem[node_raddr];
    end
  end

  // Checks on the walk and the sequencer.
  `TDVC_ASSERT_SAME(a_cursor_allocated, clk, rst_n, 1'b1, cursor_r <= nodes_used_r,
    "cursor points beyond the allocated nodes")
  `TDVC_ASSERT_SAME(a_nodes_grow, clk, rst_n, $past(rst_n),
    nodes_used_r >= $past(nodes_used_r), "node allocator went backwards")
  `TDVC_ASSERT_NEXT(a_root_after_word, clk, rst_n, state_r == S_FINISH && fin_go,
    cursor_r == '0 && !walk_failed_r && out_valid_r, "walk not reset after a word")
  `TDVC_ASSERT_SAME(a_result_from_finish, clk, rst_n, $rose(out_valid_r),
    $past(state_r) == S_FINISH, "result raised outside word completion")

endmodule

`default_nettype wire
